/* rtl/icdg_pkg.sv */
// ============================================================================
// icdg_pkg
// Shared constants and types of the central difference gradient core.
// ============================================================================
`default_nettype none

package icdg_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_PIXEL_BITS = 16;
   localparam int QUEUE_DEPTH        = 4;

   localparam int FRAME_WIDTH_BITS  = 11;
   localparam int FRAME_HEIGHT_BITS = 13;
   localparam int ROW_BITS          = 12;
   localparam int MAX_HEIGHT        = 4096;

   localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_FLUSH = 1'b1
   } cmd_type;

endpackage

`default_nettype wire

/* rtl/icdg_ram.sv */
// ============================================================================
// icdg_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
`default_nettype none

module icdg_ram #(
   parameter  int WIDTH = 16,
   parameter  int DEPTH = 1024,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [AW-1:0]            rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/icdg_front.sv */
// ============================================================================
// icdg_front
// Accepts commands, tracks the raster position, reads and updates the two
// line stores and hands the neighbor pixels of each result to the queue.
// ============================================================================
`default_nettype none

module icdg_front #(
   parameter  int MAX_WIDTH   = icdg_pkg::DEFAULT_MAX_WIDTH,
   parameter  int PIXEL_BITS  = icdg_pkg::DEFAULT_PIXEL_BITS,
   parameter  int QUEUE_DEPTH = icdg_pkg::QUEUE_DEPTH,
   localparam int CW          = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic [icdg_pkg::FRAME_WIDTH_BITS-1:0]  frame_width,
   input  wire logic [icdg_pkg::FRAME_HEIGHT_BITS-1:0] frame_height,
   input  wire logic                                   req_push,
   output logic                                        req_full,
   input  wire logic                                   req_cmd,
   input  wire logic [PIXEL_BITS-1:0]                  req_pixel_value,
   input  wire logic [CW-1:0]                          queue_count,
   output logic                                        op_push,
   output logic      [PIXEL_BITS-1:0]                  op_left,
   output logic      [PIXEL_BITS-1:0]                  op_right,
   output logic      [PIXEL_BITS-1:0]                  op_mid,
   output logic      [PIXEL_BITS-1:0]                  op_up,
   output logic                                        op_done
);

   localparam int FW  = CW + 1;
   localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int MWB = $clog2(MAX_WIDTH + 1);
   localparam int EW  = (MWB > icdg_pkg::FRAME_WIDTH_BITS) ? MWB : icdg_pkg::FRAME_WIDTH_BITS;
   localparam int HB  = icdg_pkg::FRAME_HEIGHT_BITS;
   localparam int RB  = icdg_pkg::ROW_BITS;

   typedef enum logic [1:0] {
      LEFT_NEWER_MID,
      LEFT_OLDER_PREV,
      LEFT_NEWER_PREV
   } left_sel_type;

   logic [AW-1:0]         col_ff, col_in;
   logic [RB-1:0]         row_ff, row_in;
   logic                  flushing_ff, flushing_in;
   logic                  owr_valid_ff, owr_valid_in;
   logic [AW-1:0]         owr_addr_ff, owr_addr_in;
   logic                  fwd_mid_ff, fwd_mid_in;
   logic                  fwd_prev_ff, fwd_prev_in;
   logic [PIXEL_BITS-1:0] fwd_data_ff, fwd_data_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_flush_ff, s1_flush_in;
   left_sel_type          s1_left_ff, s1_left_in;
   logic                  s1_up_newer_ff, s1_up_newer_in;
   logic                  s1_done_ff, s1_done_in;
   logic [PIXEL_BITS-1:0] s1_pix_ff, s1_pix_in;

   logic [EW-1:0]         fw_ext, eff_w, col_next;
   logic [HB-1:0]         eff_h, row_next;
   logic                  last_col, last_row;
   logic [AW-1:0]         right_addr, prev_addr;
   logic                  accept, is_flush, pix_take, flush_take;

   logic [PIXEL_BITS-1:0] newer_mid_q, newer_right_q, newer_prev_q;
   logic [PIXEL_BITS-1:0] older_mid_q, older_prev_q;
   logic [PIXEL_BITS-1:0] older_mid, older_prev;

   // effective frame size, clamped to the supported range
   always_comb begin
      fw_ext = EW'(frame_width);
      if (frame_width == '0) begin
         eff_w = EW'(1);
      end else if (fw_ext > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = fw_ext;
      end
      if (frame_height == '0) begin
         eff_h = HB'(1);
      end else if (frame_height > HB'(icdg_pkg::MAX_HEIGHT)) begin
         eff_h = HB'(icdg_pkg::MAX_HEIGHT);
      end else begin
         eff_h = frame_height;
      end
   end

   assign col_next   = EW'(col_ff) + EW'(1);
   assign row_next   = HB'(row_ff) + HB'(1);
   assign last_col   = col_next >= eff_w;
   assign last_row   = row_next >= eff_h;
   assign right_addr = (col_next < eff_w) ? col_next[AW-1:0] : AW'(eff_w - EW'(1));
   assign prev_addr  = (col_ff == '0) ? '0 : col_ff - AW'(1);

   assign req_full   = (FW'(queue_count) + FW'(s1_valid_ff)) >= FW'(QUEUE_DEPTH);
   assign accept     = req_push && !req_full;
   assign is_flush   = req_cmd == icdg_pkg::CMD_FLUSH;
   assign pix_take   = accept && !is_flush && !flushing_ff;
   assign flush_take = accept && is_flush && flushing_ff;

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      flushing_in = flushing_ff;
      if (pix_take) begin
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in      = '0;
               flushing_in = 1'b1;
            end else begin
               row_in = row_next[RB-1:0];
            end
         end else begin
            col_in = col_next[AW-1:0];
         end
      end else if (flush_take) begin
         if (last_col) begin
            col_in      = '0;
            row_in      = '0;
            flushing_in = 1'b0;
         end else begin
            col_in = col_next[AW-1:0];
         end
      end
   end

   // older store is written in the cycle after the newer store read; forward it
   assign owr_valid_in = pix_take;
   assign owr_addr_in  = col_ff;
   assign fwd_mid_in   = owr_valid_ff && (col_ff == owr_addr_ff);
   assign fwd_prev_in  = owr_valid_ff && (prev_addr == owr_addr_ff);
   assign fwd_data_in  = newer_mid_q;

   assign s1_valid_in    = (pix_take && (row_ff != '0)) || flush_take;
   assign s1_flush_in    = is_flush;
   assign s1_up_newer_in = is_flush ? (eff_h == HB'(1)) : (row_ff == RB'(1));
   assign s1_done_in     = is_flush && last_col;
   assign s1_pix_in      = req_pixel_value;

   always_comb begin
      if (is_flush) begin
         s1_left_in = LEFT_NEWER_PREV;
      end else if (col_ff == '0) begin
         s1_left_in = LEFT_NEWER_MID;
      end else begin
         s1_left_in = LEFT_OLDER_PREV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         flushing_ff  <= 1'b0;
         owr_valid_ff <= 1'b0;
         fwd_mid_ff   <= 1'b0;
         fwd_prev_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         flushing_ff  <= flushing_in;
         owr_valid_ff <= owr_valid_in;
         fwd_mid_ff   <= fwd_mid_in;
         fwd_prev_ff  <= fwd_prev_in;
         s1_valid_ff  <= s1_valid_in;
      end
      owr_addr_ff    <= owr_addr_in;
      fwd_data_ff    <= fwd_data_in;
      s1_flush_ff    <= s1_flush_in;
      s1_left_ff     <= s1_left_in;
      s1_up_newer_ff <= s1_up_newer_in;
      s1_done_ff     <= s1_done_in;
      s1_pix_ff      <= s1_pix_in;
   end

   icdg_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_newer_mid (
      .clock   (clock),
      .wr_en   (pix_take),
      .wr_addr (col_ff),
      .wr_data (req_pixel_value),
      .rd_addr (col_ff),
      .rd_data (newer_mid_q)
   );

   icdg_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_newer_right (
      .clock   (clock),
      .wr_en   (pix_take),
      .wr_addr (col_ff),
      .wr_data (req_pixel_value),
      .rd_addr (right_addr),
      .rd_data (newer_right_q)
   );

   icdg_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_newer_prev (
      .clock   (clock),
      .wr_en   (pix_take),
      .wr_addr (col_ff),
      .wr_data (req_pixel_value),
      .rd_addr (prev_addr),
      .rd_data (newer_prev_q)
   );

   icdg_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_older_mid (
      .clock   (clock),
      .wr_en   (owr_valid_ff),
      .wr_addr (owr_addr_ff),
      .wr_data (newer_mid_q),
      .rd_addr (col_ff),
      .rd_data (older_mid_q)
   );

   icdg_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_older_prev (
      .clock   (clock),
      .wr_en   (owr_valid_ff),
      .wr_addr (owr_addr_ff),
      .wr_data (newer_mid_q),
      .rd_addr (prev_addr),
      .rd_data (older_prev_q)
   );

   assign older_mid  = fwd_mid_ff  ? fwd_data_ff : older_mid_q;
   assign older_prev = fwd_prev_ff ? fwd_data_ff : older_prev_q;

   always_comb begin
      case (s1_left_ff)
         LEFT_NEWER_MID:  op_left = newer_mid_q;
         LEFT_OLDER_PREV: op_left = older_prev;
         default:         op_left = newer_prev_q;
      endcase
   end

   assign op_push  = s1_valid_ff;
   assign op_right = newer_right_q;
   assign op_mid   = s1_flush_ff ? newer_mid_q : s1_pix_ff;
   assign op_up    = s1_up_newer_ff ? newer_mid_q : older_mid;
   assign op_done  = s1_done_ff;

endmodule

`default_nettype wire

/* rtl/icdg_fifo.sv */
// ============================================================================
// icdg_fifo
// Small register queue between the front and the back.
// ============================================================================
`default_nettype none

module icdg_fifo #(
   parameter  int WIDTH = 65,
   parameter  int DEPTH = icdg_pkg::QUEUE_DEPTH,
   localparam int CW    = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty,
   output logic      [CW-1:0]    count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + PW'(1);
      end
      if (do_pop) begin
         head_in = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + PW'(1);
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[tail_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[head_ff];
   assign empty    = count_ff == '0;
   assign count    = count_ff;

endmodule

`default_nettype wire

/* rtl/icdg_back.sv */
// ============================================================================
// icdg_back
// Takes neighbor sets from the queue, forms both differences and holds the
// result in the output register until it is popped.
// ============================================================================
`default_nettype none

module icdg_back #(
   parameter int PIXEL_BITS = icdg_pkg::DEFAULT_PIXEL_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       fifo_empty,
   input  wire logic [4*PIXEL_BITS:0]      fifo_data,
   output logic                            fifo_pop,
   output logic                            rsp_empty,
   input  wire logic                       rsp_pop,
   output logic signed [PIXEL_BITS:0]      rsp_grad_x,
   output logic signed [PIXEL_BITS:0]      rsp_grad_y,
   output logic                            rsp_frame_done
);

   localparam int GW = PIXEL_BITS + 1;

   logic [PIXEL_BITS-1:0] left, right, mid, up;
   logic                  done;
   logic                  load;
   logic                  valid_ff, valid_in;
   logic [GW-1:0]         gx_ff, gx_in;
   logic [GW-1:0]         gy_ff, gy_in;
   logic                  done_ff;

   assign {left, right, mid, up, done} = fifo_data;

   assign load     = !fifo_empty && (!valid_ff || rsp_pop);
   assign fifo_pop = load;
   assign valid_in = load || (valid_ff && !rsp_pop);
   assign gx_in    = {1'b0, right} - {1'b0, left};
   assign gy_in    = {1'b0, mid} - {1'b0, up};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         gx_ff   <= gx_in;
         gy_ff   <= gy_in;
         done_ff <= done;
      end
   end

   assign rsp_empty      = !valid_ff;
   assign rsp_grad_x     = signed'(gx_ff);
   assign rsp_grad_y     = signed'(gy_ff);
   assign rsp_frame_done = done_ff;

endmodule

`default_nettype wire

/* rtl/image_central_difference_gradient_core.sv */
// ============================================================================
// image_central_difference_gradient_core
// Central difference gradient over a raster pixel stream with two line
// stores; results lag one row and a flush command drains the last row.
//
//   channel   ports   direction  transfer when
//   request   req_*   in         req_push & !req_full
//   response  rsp_*   out        rsp_pop & !rsp_empty
//   config    csr_*   in/out     csr_psel & csr_penable & csr_pwrite
//
// One command per clock while req_full is low; each result passes the front
// stage register, the queue and the output register, then shows on rsp_*.
// Line store reads are issued at the accept edge; the older store is written
// in the following cycle with forwarding to the next read.
// req_full rises when the four entry queue plus the item in flight is full.
// Reset clears counters, queue and output register; line stores hold garbage
// until written.
// ============================================================================
`default_nettype none

module image_central_difference_gradient_core #(
   parameter int MAX_WIDTH  = icdg_pkg::DEFAULT_MAX_WIDTH,
   parameter int PIXEL_BITS = icdg_pkg::DEFAULT_PIXEL_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic                                req_cmd,
   input  wire logic [PIXEL_BITS-1:0]               req_pixel_value,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic signed [PIXEL_BITS:0]               rsp_grad_x,
   output logic signed [PIXEL_BITS:0]               rsp_grad_y,
   output logic                                     rsp_frame_done,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [icdg_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [icdg_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic      [icdg_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                     csr_pready
);

   localparam int QD = icdg_pkg::QUEUE_DEPTH;
   localparam int CW = $clog2(QD + 1);
   localparam int OW = 4 * PIXEL_BITS + 1;
   localparam int DW = icdg_pkg::CSR_DATA_BITS;

   logic [icdg_pkg::FRAME_WIDTH_BITS-1:0]  frame_width_ff, frame_width_in;
   logic [icdg_pkg::FRAME_HEIGHT_BITS-1:0] frame_height_ff, frame_height_in;
   logic                                   csr_write;
   icdg_pkg::reg_index_type                csr_index;

   logic                  op_push, op_done;
   logic [PIXEL_BITS-1:0] op_left, op_right, op_mid, op_up;
   logic [OW-1:0]         fifo_data;
   logic                  fifo_pop, fifo_empty;
   logic [CW-1:0]         fifo_count;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = icdg_pkg::reg_index_type'(csr_paddr[icdg_pkg::CSR_ADDR_BITS-1]);

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write) begin
         case (csr_index)
            icdg_pkg::REG_FRAME_WIDTH:
               frame_width_in = csr_pwdata[icdg_pkg::FRAME_WIDTH_BITS-1:0];
            icdg_pkg::REG_FRAME_HEIGHT:
               frame_height_in = csr_pwdata[icdg_pkg::FRAME_HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         icdg_pkg::REG_FRAME_WIDTH:  csr_prdata = DW'(frame_width_ff);
         icdg_pkg::REG_FRAME_HEIGHT: csr_prdata = DW'(frame_height_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= icdg_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= icdg_pkg::FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   icdg_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .PIXEL_BITS  (PIXEL_BITS),
      .QUEUE_DEPTH (QD)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .frame_width     (frame_width_ff),
      .frame_height    (frame_height_ff),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_pixel_value (req_pixel_value),
      .queue_count     (fifo_count),
      .op_push         (op_push),
      .op_left         (op_left),
      .op_right        (op_right),
      .op_mid          (op_mid),
      .op_up           (op_up),
      .op_done         (op_done)
   );

   icdg_fifo #(
      .WIDTH (OW),
      .DEPTH (QD)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data ({op_left, op_right, op_mid, op_up, op_done}),
      .pop       (fifo_pop),
      .pop_data  (fifo_data),
      .empty     (fifo_empty),
      .count     (fifo_count)
   );

   icdg_back #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .fifo_empty     (fifo_empty),
      .fifo_data      (fifo_data),
      .fifo_pop       (fifo_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_grad_x     (rsp_grad_x),
      .rsp_grad_y     (rsp_grad_y),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

`default_nettype wire

/* rtl/icdg_checker.sv */
// ============================================================================
// icdg_checker
// Port level checks of the gradient core, bound to the top level.
// ============================================================================
`default_nettype none

module icdg_checker #(
   parameter int PIXEL_BITS = icdg_pkg::DEFAULT_PIXEL_BITS
) (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_push,
   input wire logic                        req_full,
   input wire logic                        rsp_empty,
   input wire logic                        rsp_pop,
   input wire logic signed [PIXEL_BITS:0]  rsp_grad_x,
   input wire logic signed [PIXEL_BITS:0]  rsp_grad_y,
   input wire logic                        rsp_frame_done
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_grad_x) && $stable(rsp_grad_y)
          && $stable(rsp_frame_done)))
      else $error("stalled result changed");

   // a result that appears in an empty output must trace back to an accepted command
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_empty ##1 !rsp_empty) |-> $past(req_push && !req_full, 3))
      else $error("result without a preceding transfer");

endmodule

bind image_central_difference_gradient_core icdg_checker #(
   .PIXEL_BITS (PIXEL_BITS)
) u_icdg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_push       (req_push),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_grad_x     (rsp_grad_x),
   .rsp_grad_y     (rsp_grad_y),
   .rsp_frame_done (rsp_frame_done)
);

`default_nettype wire
